// ===== src/cam_pkg.sv =====
// Shared constants, types and the month length function for calendar_add_minutes.
package cam_pkg;

    localparam int DEF_ADD_MINUTES_BITS = 16;

    // Width of the step constants that the shared subtractor takes; 1440 fits in 11 bits.
    localparam int DIV_W = 11;

    localparam logic [DIV_W-1:0] MIN_PER_DAY  = DIV_W'(24 * 60);
    localparam logic [DIV_W-1:0] MIN_PER_HOUR = DIV_W'(60);

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
    } t_date;

    typedef struct packed {
        logic load;
        logic step;
    } t_date_cmd;

    // Days in a month; months outside one to twelve count as 31 days.
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        len = 5'd31;
        if (month == MONTH_FEB) begin
            len = leap ? 5'd29 : 5'd28;
        end else if (month >= 4'd1 && month <= MONTH_DEC) begin
            len = MONTH_LEN[month - 4'd1];
        end
        return len;
    endfunction

endpackage

// ===== src/calendar_add_minutes.sv =====
// Top level of calendar_add_minutes: sequencer, input capture and result register.
// Adds a minute count to a date and time whose year means 2000 plus the year. A month
// or day of zero counts as one, and the second is copied through. The total minute
// count (hour times 60, plus minute, plus i_add_minutes) is loaded into one shared
// compare-and-subtract unit. While the count still holds a whole day, each cycle takes
// 1440 off it and steps the date by one day through the month lengths with the
// Gregorian leap rule; then each cycle takes 60 off the minute of day and counts the
// hour, and what is left is the minute. The day loop steps once per whole day and the
// hour loop once per hour, and a result that waits on i_stall holds the sequencer in
// S_DONE until the result register is free. While an item is in work o_stall stays
// high; a finished result sits in the output register until its transfer, and the
// next item may be taken meanwhile.
module calendar_add_minutes #(
    parameter int ADD_MINUTES_BITS = cam_pkg::DEF_ADD_MINUTES_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [6:0]                  i_base_year,
    input  logic [3:0]                  i_base_month,
    input  logic [4:0]                  i_base_day,
    input  logic [4:0]                  i_base_hour,
    input  logic [5:0]                  i_base_minute,
    input  logic [5:0]                  i_base_second,
    input  logic [ADD_MINUTES_BITS-1:0] i_add_minutes,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [6:0]                  o_new_year,
    output logic [3:0]                  o_new_month,
    output logic [4:0]                  o_new_day,
    output logic [4:0]                  o_new_hour,
    output logic [5:0]                  o_new_minute,
    output logic [5:0]                  o_new_second
);
    import cam_pkg::*;

    // The hour and minute fields add at most 1923, which needs DIV_W bits.
    localparam int TOT_W = ((ADD_MINUTES_BITS > DIV_W) ? ADD_MINUTES_BITS : DIV_W) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DAY,
        S_HOUR,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [4:0]          r_hour;
    logic [5:0]          r_second;
    logic                r_out_valid;
    logic [6:0]          r_out_year;
    logic [3:0]          r_out_month;
    logic [4:0]          r_out_day;
    logic [4:0]          r_out_hour;
    logic [5:0]          r_out_minute;
    logic [5:0]          r_out_second;

    logic                accept;
    logic                out_free;
    logic [TOT_W-1:0]    total;
    t_date               base;
    t_date               cur_date;
    t_date_cmd           date_cmd;

    logic                div_sub;
    logic [DIV_W-1:0]    div_divisor;
    logic                div_ge;
    logic [TOT_W-1:0]    div_rem;

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && !o_stall;
    // The result register can take a new result when empty or when its transfer
    // completes at this edge.
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        total = TOT_W'(i_base_hour) * TOT_W'(MIN_PER_HOUR)
              + TOT_W'(i_base_minute)
              + TOT_W'(i_add_minutes);

        base.year  = i_base_year;
        base.month = (i_base_month == 4'd0) ? 4'd1 : i_base_month;
        base.day   = (i_base_day == 5'd0) ? 5'd1 : i_base_day;

        // The day loop takes whole days off the count, the hour loop whole hours.
        div_divisor = (r_state == S_HOUR) ? MIN_PER_HOUR : MIN_PER_DAY;
        div_sub     = (r_state == S_DAY) || (r_state == S_HOUR);

        date_cmd.load = accept;
        date_cmd.step = (r_state == S_DAY) && div_ge;
    end

    cam_div #(
        .DVD_W (TOT_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (accept),
        .i_value   (total),
        .i_sub     (div_sub),
        .i_divisor (div_divisor),
        .o_ge      (div_ge),
        .o_rem     (div_rem)
    );

    cam_date u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (date_cmd),
        .i_base  (base),
        .o_date  (cur_date)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // In S_DONE a free result register is always refilled below.
            if (r_out_valid && !i_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_second <= i_base_second;
                        r_hour   <= '0;
                        r_state  <= S_DAY;
                    end
                end
                S_DAY: begin
                    if (!div_ge) begin
                        r_state <= S_HOUR;
                    end
                end
                S_HOUR: begin
                    // The minute of day is below 1440, so the hour stays below 24.
                    if (div_ge) begin
                        r_hour <= r_hour + 5'd1;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_year   <= cur_date.year;
                        r_out_month  <= cur_date.month;
                        r_out_day    <= cur_date.day;
                        r_out_hour   <= r_hour;
                        r_out_minute <= div_rem[5:0];
                        r_out_second <= r_second;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_new_year   = r_out_year;
    assign o_new_month  = r_out_month;
    assign o_new_day    = r_out_day;
    assign o_new_hour   = r_out_hour;
    assign o_new_minute = r_out_minute;
    assign o_new_second = r_out_second;

`ifndef SYNTHESIS
    a_day_subtract: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DAY && div_ge) |=> (div_rem == $past(div_rem) - TOT_W'(MIN_PER_DAY)))
        else $error("day loop did not take one day off the count");

    a_hour_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOUR) |-> (div_rem < TOT_W'(MIN_PER_DAY)))
        else $error("minute of day out of range in the hour loop");

    a_minute_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (div_rem < TOT_W'(MIN_PER_HOUR)))
        else $error("minute out of range at the end of the hour loop");

    a_time_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_new_hour <= 5'd23 && o_new_minute <= 6'd59))
        else $error("result time of day out of range");

    a_date_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_new_month != 4'd0 && o_new_day != 5'd0))
        else $error("result month or day is zero");
`endif

endmodule

// ===== src/cam_div.sv =====
// Shared compare-and-subtract unit that takes a constant step off a minute count.
module cam_div #(
    parameter int DVD_W = 17
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic [DVD_W-1:0]          i_value,
    input  logic                      i_sub,
    input  logic [cam_pkg::DIV_W-1:0] i_divisor,
    output logic                      o_ge,
    output logic [DVD_W-1:0]          o_rem
);
    import cam_pkg::*;

    logic [DVD_W-1:0] r_rem;

    logic [DVD_W-1:0] dvs;
    logic             ge;

    always_comb begin
        dvs = DVD_W'(i_divisor);
        ge  = (r_rem >= dvs);
    end

    // A subtraction only happens while the remainder still holds a whole step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (i_load) begin
            r_rem <= i_value;
        end else if (i_sub && ge) begin
            r_rem <= r_rem - dvs;
        end
    end

    assign o_ge  = ge;
    assign o_rem = r_rem;

endmodule

// ===== src/cam_date.sv =====
// Date register with a one-day step unit and incremental leap-year tracking.
module cam_date (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cam_pkg::t_date_cmd i_cmd,
    input  cam_pkg::t_date     i_base,
    output cam_pkg::t_date     o_date
);
    import cam_pkg::*;

    // The full year is 2000 plus the offset; 2000 is a multiple of 400, so the
    // residues below start from the offset itself and follow every increment.
    logic [1:0] r_mod4;
    logic [6:0] r_mod100;
    logic [8:0] r_mod400;
    t_date      r_date;

    logic       leap;
    logic [4:0] len;

    always_comb begin
        leap = ((r_mod4 == 2'd0) && (r_mod100 != 7'd0)) || (r_mod400 == 9'd0);
        len  = month_days(r_date.month, leap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_date   <= '0;
            r_mod4   <= '0;
            r_mod100 <= '0;
            r_mod400 <= '0;
        end else if (i_cmd.load) begin
            r_date   <= i_base;
            r_mod4   <= i_base.year[1:0];
            r_mod100 <= (i_base.year >= 7'd100) ? i_base.year - 7'd100 : i_base.year;
            r_mod400 <= {2'b00, i_base.year};
        end else if (i_cmd.step) begin
            if (r_date.day < len) begin
                r_date.day <= r_date.day + 5'd1;
            end else begin
                r_date.day <= 5'd1;
                if (r_date.month < MONTH_DEC) begin
                    r_date.month <= r_date.month + 4'd1;
                end else begin
                    r_date.month <= 4'd1;
                    r_date.year  <= r_date.year + 7'd1;
                    r_mod4       <= r_mod4 + 2'd1;
                    r_mod100     <= (r_mod100 == 7'd99) ? 7'd0 : r_mod100 + 7'd1;
                    r_mod400     <= (r_mod400 == 9'd399) ? 9'd0 : r_mod400 + 9'd1;
                end
            end
        end
    end

    assign o_date = r_date;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for calendar_add_minutes with bursty input and random output stalls.
`timescale 1ns / 1ps

module tb;

    localparam int ADD_W = 16;

    // One request to the block: a base date and time plus the minutes to add.
    typedef struct {
        logic [6:0]       year;
        logic [3:0]       month;
        logic [4:0]       day;
        logic [4:0]       hour;
        logic [5:0]       minute;
        logic [5:0]       second;
        logic [ADD_W-1:0] add;
    } t_date_request;

    // The date and time that the block should return for one request.
    typedef struct {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_date_result;

    // Patterns for the output side. Each one holds for a random run of cycles.
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_SPARSE,
        STALL_HALF,
        STALL_HOLD
    } t_stall_mode;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic [6:0]       i_base_year = '0;
    logic [3:0]       i_base_month = '0;
    logic [4:0]       i_base_day = '0;
    logic [4:0]       i_base_hour = '0;
    logic [5:0]       i_base_minute = '0;
    logic [5:0]       i_base_second = '0;
    logic [ADD_W-1:0] i_add_minutes = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [6:0]       o_new_year;
    logic [3:0]       o_new_month;
    logic [4:0]       o_new_day;
    logic [4:0]       o_new_hour;
    logic [5:0]       o_new_minute;
    logic [5:0]       o_new_second;

    // Requests waiting to be driven, and predicted dates waiting for their transfer.
    t_date_request pending_requests[$];
    t_date_result  expected_dates[$];
    t_date_request request_on_bus;

    int unsigned total_requests = 0;
    int unsigned accepted_requests = 0;
    int unsigned checked_results = 0;
    int unsigned error_count = 0;

    // Sender burst shaping: items left in the current burst, idle cycles before the next.
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    // Receiver stall pattern and how many more cycles it lasts.
    t_stall_mode stall_mode = STALL_NONE;
    int unsigned stall_run = 0;

    calendar_add_minutes #(
        .ADD_MINUTES_BITS(ADD_W)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_base_year   (i_base_year),
        .i_base_month  (i_base_month),
        .i_base_day    (i_base_day),
        .i_base_hour   (i_base_hour),
        .i_base_minute (i_base_minute),
        .i_base_second (i_base_second),
        .i_add_minutes (i_add_minutes),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_new_year    (o_new_year),
        .o_new_month   (o_new_month),
        .o_new_day     (o_new_day),
        .o_new_hour    (o_new_hour),
        .o_new_minute  (o_new_minute),
        .o_new_second  (o_new_second)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Computes the date and time a request should produce. The year is carried as the
    // full year so that the century rules of the leap test apply, and it is never
    // wrapped until it is cut to seven bits at the end.
    function automatic t_date_result add_to_date(t_date_request rq);
        int unsigned  yr;
        int unsigned  mo;
        int unsigned  dy;
        int unsigned  total;
        int unsigned  days;
        int unsigned  len;
        bit           leap;
        t_date_result res;
        yr = 2000 + int'(rq.year);
        mo = (rq.month == 4'd0) ? 1 : int'(rq.month);
        dy = (rq.day == 5'd0) ? 1 : int'(rq.day);
        // Out-of-range hours and minutes simply add into the total.
        total = int'(rq.hour) * 60 + int'(rq.minute) + int'(rq.add);
        days = total / 1440;
        while (days > 0) begin
            leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
            case (mo)
                2:            len = leap ? 29 : 28;
                4, 6, 9, 11:  len = 30;
                // Months thirteen to fifteen count as 31 days long, like the 31-day months.
                default:      len = 31;
            endcase
            // A day past the month's end steps straight to the first of the next month.
            if (dy < len) begin
                dy++;
            end else begin
                dy = 1;
                if (mo < 12) begin
                    mo++;
                end else begin
                    mo = 1;
                    yr++;
                end
            end
            days--;
        end
        res.year   = 7'(yr - 2000);
        res.month  = 4'(mo);
        res.day    = 5'(dy);
        res.hour   = 5'((total % 1440) / 60);
        res.minute = 6'(total % 60);
        res.second = rq.second;
        return res;
    endfunction

    function automatic t_date_request make_request(int unsigned yr, int unsigned mo,
                                                   int unsigned dy, int unsigned hr,
                                                   int unsigned mi, int unsigned se,
                                                   int unsigned add);
        t_date_request rq;
        rq.year   = 7'(yr);
        rq.month  = 4'(mo);
        rq.day    = 5'(dy);
        rq.hour   = 5'(hr);
        rq.minute = 6'(mi);
        rq.second = 6'(se);
        rq.add    = ADD_W'(add);
        return rq;
    endfunction

    task automatic report_failure(input string msg);
        $display("ERROR at %0t ns: %s", $realtime, msg);
        error_count++;
    endtask

    // Driver. It holds a request steady while the block stalls it, records the
    // prediction on each transfer, and between bursts leaves the input idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_dates.push_back(add_to_date(request_on_bus));
                accepted_requests++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    request_on_bus = pending_requests.pop_front();
                    i_base_year   <= request_on_bus.year;
                    i_base_month  <= request_on_bus.month;
                    i_base_day    <= request_on_bus.day;
                    i_base_hour   <= request_on_bus.hour;
                    i_base_minute <= request_on_bus.minute;
                    i_base_second <= request_on_bus.second;
                    i_add_minutes <= request_on_bus.add;
                    i_valid       <= 1'b1;
                    // At the end of a burst pick the next burst length and the pause
                    // before it. A quarter of the pauses are empty, so bursts often run
                    // back to back.
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. It drives the output stall from a pattern that changes every so often
    // and checks each transfer against the oldest prediction.
    always @(posedge i_clk) begin
        t_date_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_dates.size() == 0) begin
                    report_failure("result transfer with no request outstanding");
                end else begin
                    want = expected_dates.pop_front();
                    if (o_new_year !== want.year)
                        report_failure($sformatf("result %0d: year %0d, expected %0d",
                                                 checked_results, o_new_year, want.year));
                    if (o_new_month !== want.month)
                        report_failure($sformatf("result %0d: month %0d, expected %0d",
                                                 checked_results, o_new_month, want.month));
                    if (o_new_day !== want.day)
                        report_failure($sformatf("result %0d: day %0d, expected %0d",
                                                 checked_results, o_new_day, want.day));
                    if (o_new_hour !== want.hour)
                        report_failure($sformatf("result %0d: hour %0d, expected %0d",
                                                 checked_results, o_new_hour, want.hour));
                    if (o_new_minute !== want.minute)
                        report_failure($sformatf("result %0d: minute %0d, expected %0d",
                                                 checked_results, o_new_minute,
                                                 want.minute));
                    if (o_new_second !== want.second)
                        report_failure($sformatf("result %0d: second %0d, expected %0d",
                                                 checked_results, o_new_second,
                                                 want.second));
                end
                checked_results++;
            end
            // Long holds are kept short enough that the run does not crawl.
            if (stall_run == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                stall_run = (stall_mode == STALL_HOLD) ? $urandom_range(1, 60)
                                                       : $urandom_range(5, 200);
            end else begin
                stall_run--;
            end
            case (stall_mode)
                STALL_NONE:   i_stall <= 1'b0;
                STALL_SPARSE: i_stall <= ($urandom_range(0, 7) == 0);
                STALL_HALF:   i_stall <= ($urandom_range(0, 1) == 1);
                default:      i_stall <= 1'b1;
            endcase
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        t_date_request rq;
        int unsigned   k;

        // Directed part. Month and day of zero read as the first.
        pending_requests.push_back(make_request(0, 0, 0, 0, 0, 0, 0));
        // Every field at its largest encoding, including hour 31 and minute 63.
        pending_requests.push_back(make_request(127, 15, 31, 31, 63, 63, 65535));
        // The last minute of year 99 rolls into year 100 without wrapping.
        pending_requests.push_back(make_request(99, 12, 31, 23, 59, 30, 1));
        // Past year 127 the result shows only the low seven bits.
        pending_requests.push_back(make_request(127, 12, 31, 0, 0, 1, 1440));
        // February 28 in 2000 (leap by the 400 rule), 2100 (not leap) and 2096 (leap).
        pending_requests.push_back(make_request(0, 2, 28, 12, 0, 2, 1440));
        pending_requests.push_back(make_request(100, 2, 28, 12, 0, 3, 1440));
        pending_requests.push_back(make_request(96, 2, 28, 12, 0, 4, 2880));
        // February 29 of a common year and April 31 both step to the next month.
        pending_requests.push_back(make_request(1, 2, 29, 0, 0, 5, 1440));
        pending_requests.push_back(make_request(21, 4, 31, 6, 30, 6, 1440));
        // A day beyond the month length passes through when no whole day is added.
        pending_requests.push_back(make_request(23, 2, 31, 10, 10, 7, 100));
        // Months thirteen to fifteen: roll into January, pass through, run off the end.
        pending_requests.push_back(make_request(50, 13, 31, 0, 0, 8, 1440));
        pending_requests.push_back(make_request(50, 14, 5, 1, 2, 9, 0));
        pending_requests.push_back(make_request(50, 15, 20, 0, 0, 10, 20 * 1440));
        // Hour and minute out of range carry into the day count.
        pending_requests.push_back(make_request(10, 6, 30, 30, 0, 11, 0));
        pending_requests.push_back(make_request(10, 6, 30, 23, 63, 12, 0));
        // One minute short of a day and exactly a day.
        pending_requests.push_back(make_request(4, 1, 1, 0, 0, 13, 1439));
        pending_requests.push_back(make_request(4, 1, 1, 0, 0, 14, 1440));
        // The largest count from the first day of a year and from a leap day.
        pending_requests.push_back(make_request(0, 1, 1, 0, 0, 15, 65535));
        pending_requests.push_back(make_request(0, 2, 29, 23, 59, 16, 65535));
        pending_requests.push_back(make_request(0, 0, 0, 31, 63, 59, 65535));
        pending_requests.push_back(make_request(99, 12, 1, 0, 0, 42, 45 * 1440));
        pending_requests.push_back(make_request(42, 8, 31, 23, 59, 63, 60));

        // Random part. Most requests are valid dates and times; the rest use the full
        // width of every field so that every input bit toggles.
        for (int n = 0; n < 1550; n++) begin
            if ($urandom_range(0, 3) != 0) begin
                rq.year   = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(100, 127))
                                                        : 7'($urandom_range(0, 99));
                rq.month  = 4'($urandom_range(1, 12));
                rq.day    = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(27, 31))
                                                        : 5'($urandom_range(1, 28));
                rq.hour   = 5'($urandom_range(0, 23));
                rq.minute = 6'($urandom_range(0, 59));
                rq.second = 6'($urandom_range(0, 59));
            end else begin
                rq.year   = 7'($urandom);
                rq.month  = 4'($urandom);
                rq.day    = 5'($urandom);
                rq.hour   = 5'($urandom);
                rq.minute = 6'($urandom);
                rq.second = 6'($urandom);
            end
            case ($urandom_range(0, 4))
                0: rq.add = ADD_W'($urandom);
                1: rq.add = ADD_W'($urandom_range(0, 100));
                2: begin
                    // Land close to a whole number of days.
                    k = $urandom_range(1, 45);
                    rq.add = ADD_W'(k * 1440 + $urandom_range(0, 4) - 2);
                end
                3: rq.add = ADD_W'($urandom_range(0, 4000));
                default: rq.add = ADD_W'($urandom_range(0, 65535));
            endcase
            pending_requests.push_back(rq);
        end
        total_requests = pending_requests.size();

        // Reset is held low from time zero and then released.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_requests < total_requests) @(posedge i_clk);
        while (expected_dates.size() != 0) @(posedge i_clk);
        // Give a stray extra result time to show up.
        repeat (200) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog. A correct run takes well under a tenth of this.
    initial begin
        #30_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
